// File: design/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared codes and the command record passed from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned QTY_W    = 24;
  localparam int unsigned PRICE_W  = 11;
  localparam int unsigned TICKER_W = 2;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned ACT_W    = 3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MATCH  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_QTY   = 3'd1,
    ST_BAD_PRICE  = 3'd2,
    ST_BAD_TICKER = 3'd3,
    ST_BAD_ID     = 3'd4,
    ST_NO_MATCH   = 3'd5,
    ST_BOOK_FULL  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    K_REPORT = 2'd0,
    K_ADD    = 2'd1,
    K_CANCEL = 2'd2,
    K_MATCH  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [TICKER_W-1:0]   ticker;
    logic                  side;
    logic [QTY_W-1:0]      qty;
    logic [PRICE_W-1:0]    tick;
    logic [ID_W-1:0]       id;
    logic [LIMIT_W-1:0]    lim;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/lobm_mod.sv
// ----------------------------------------------------------------------------
// lobm_mod
// Order id to slot index: id modulo the slot count, four bits per cycle with
// a compare-and-subtract ladder when the slot count is not a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_mod #(
  parameter int unsigned DIVISOR = 2048
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                num_i,
  output logic                            done_o,
  output logic [$clog2(DIVISOR)-1:0]      rem_o
);

  localparam int unsigned SW = $clog2(DIVISOR);

  if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_pow2
    logic          done_q;
    logic [SW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
        rem_q  <= '0;
      end else begin
        done_q <= start_i;
        if (start_i) begin
          rem_q <= num_i[SW-1:0];
        end
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_serial
    logic          busy_q;
    logic          done_q;
    logic [2:0]    dig_q;
    logic [31:0]   sh_q;
    logic [SW-1:0] r_q;
    logic [SW+3:0] acc;

    // r < DIVISOR, so {r, nibble} < 16*DIVISOR; subtract 8x, 4x, 2x, 1x
    always_comb begin
      acc = {r_q, sh_q[31:28]};
      for (int k = 3; k >= 0; k--) begin
        if (acc >= (SW+4)'(DIVISOR << k)) begin
          acc = acc - (SW+4)'(DIVISOR << k);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        dig_q  <= '0;
        sh_q   <= '0;
        r_q    <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          dig_q  <= 3'd7;
          sh_q   <= num_i;
          r_q    <= '0;
        end else if (busy_q) begin
          r_q   <= acc[SW-1:0];
          sh_q  <= {sh_q[27:0], 4'd0};
          dig_q <= dig_q - 3'd1;
          if (dig_q == 3'd0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    assign done_o = done_q;
    assign rem_o  = r_q;
  end

endmodule

`default_nettype wire

// File: design/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Input side: checks and classifies items, holds the ticker count register
// and a two-entry command queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_front #(
  parameter int unsigned TICKERS      = 4,
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned MAX_FILLS    = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lobm_pkg::ACT_W-1:0]        cfg_wdata_i,
  input  wire logic                              hold_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [lobm_pkg::TICKER_W-1:0]     ticker_index_i,
  input  wire logic                              side_sell_i,
  input  wire logic [lobm_pkg::QTY_W-1:0]        quantity_i,
  input  wire logic [lobm_pkg::PRICE_W-1:0]      price_cents_i,
  input  wire logic [lobm_pkg::ID_W-1:0]         cancel_id_i,
  input  wire logic [lobm_pkg::LIMIT_W-1:0]      fill_limit_i,
  input  wire logic                              pop_i,
  output logic                                   q_valid_o,
  output lobm_pkg::cmd_t                         q_data_o
);

  logic [lobm_pkg::ACT_W-1:0] act_q;
  lobm_pkg::cmd_t             ent_q [2];
  logic                       wr_q, rd_q;
  logic [1:0]                 cnt_q;
  lobm_pkg::cmd_t             cmd;
  logic                       ticker_ok, price_bad, push;

  assign ticker_ok = ({1'b0, ticker_index_i} < act_q) && (32'(ticker_index_i) < TICKERS);
  assign price_bad = (price_cents_i == '0) || (32'(price_cents_i) > PRICE_LEVELS);

  always_comb begin
    cmd        = '0;
    cmd.kind   = lobm_pkg::K_REPORT;
    cmd.status = lobm_pkg::ST_OK;
    cmd.ticker = ticker_index_i;
    cmd.side   = side_sell_i;
    cmd.qty    = quantity_i;
    cmd.tick   = price_cents_i - lobm_pkg::PRICE_W'(1);
    cmd.id     = cancel_id_i;
    cmd.lim    = ((fill_limit_i == '0) || (32'(fill_limit_i) > MAX_FILLS))
                 ? lobm_pkg::LIMIT_W'(MAX_FILLS) : fill_limit_i;
    unique case (lobm_pkg::opcode_e'(opcode_i))
      lobm_pkg::OP_ADD: begin
        if (quantity_i == '0) begin
          cmd.status = lobm_pkg::ST_ZERO_QTY;
        end else if (price_bad) begin
          cmd.status = lobm_pkg::ST_BAD_PRICE;
        end else if (!ticker_ok) begin
          cmd.status = lobm_pkg::ST_BAD_TICKER;
        end else begin
          cmd.kind = lobm_pkg::K_ADD;
        end
      end
      lobm_pkg::OP_CANCEL: begin
        cmd.kind = lobm_pkg::K_CANCEL;
      end
      lobm_pkg::OP_MATCH: begin
        if (!ticker_ok) begin
          cmd.status = lobm_pkg::ST_BAD_TICKER;
        end else begin
          cmd.kind = lobm_pkg::K_MATCH;
        end
      end
      default: begin
        cmd.kind = lobm_pkg::K_REPORT;
      end
    endcase
  end

  assign in_stall_o = hold_i || (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/lobm_back.sv
// ----------------------------------------------------------------------------
// lobm_back
// Execution side: order slot and price level memories, best level per book,
// add / cancel / match sequencer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_back #(
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned ORDER_SLOTS  = 2048,
  parameter int unsigned TICKERS      = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire lobm_pkg::cmd_t                q_data_i,
  output logic                               q_pop_o,
  output logic                               clearing_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [lobm_pkg::ID_W-1:0]          order_id_o,
  output logic [lobm_pkg::ID_W-1:0]          buy_id_o,
  output logic [lobm_pkg::ID_W-1:0]          sell_id_o,
  output logic [lobm_pkg::PRICE_W-1:0]       fill_price_cents_o,
  output logic [lobm_pkg::QTY_W-1:0]         fill_quantity_o,
  output logic                               last_o
);

  localparam int unsigned SW     = $clog2(ORDER_SLOTS);
  localparam int unsigned LW     = $clog2(PRICE_LEVELS);
  localparam int unsigned TW     = (TICKERS > 1) ? $clog2(TICKERS) : 1;
  localparam int unsigned BKW    = $clog2(2 * TICKERS);
  localparam int unsigned LEVELS = 2 * TICKERS * PRICE_LEVELS;
  localparam int unsigned LAW    = $clog2(LEVELS);
  localparam int unsigned CLR_N  = (ORDER_SLOTS > LEVELS) ? ORDER_SLOTS : LEVELS;
  localparam int unsigned CLRW   = $clog2(CLR_N);
  localparam int unsigned CNW    = $clog2(PRICE_LEVELS + 1);

  typedef struct packed {
    logic          v;
    logic [SW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic                       live;
    logic [lobm_pkg::ID_W-1:0]  tag;
    logic [lobm_pkg::QTY_W-1:0] qty;
    logic [LW-1:0]              tick;
    logic [BKW-1:0]             book;
    link_t                      prev;
    link_t                      next;
  } slot_rec_t;

  typedef struct packed {
    logic          active;
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
  } lvl_rec_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RPT, S_A_RD, S_A_CHK, S_A_LNK, S_A_DONE, S_C_MOD, S_C_CHK,
    S_U0, S_U1, S_U2, S_U3, S_RS, S_M_CHK, S_M_LVB, S_M_LVS, S_M_SB, S_M_SS,
    S_M_CALC, S_M_WB, S_M_WS, S_M_UB, S_M_US
  } state_e;

  typedef enum logic [1:0] {
    RET_CANCEL, RET_MB, RET_MS
  } ret_e;

  state_e                     state_q, ret_state;
  ret_e                       ret_q;
  lobm_pkg::cmd_t             cmd_q;
  logic [CLRW-1:0]            clr_q;
  logic [lobm_pkg::ID_W-1:0]  next_id_q;
  logic [SW-1:0]              next_slot_q;
  slot_rec_t                  cur_q, rb_q, rs_q;
  logic [SW-1:0]              cur_idx_q, lnk_q, head_b_q, head_s_q;
  logic                       emptied_q;
  logic [LW-1:0]              bl_q, sl_q;
  logic [lobm_pkg::LIMIT_W-1:0] cnt_q;
  logic                       pf_v_q;
  logic [lobm_pkg::ID_W-1:0]  pf_bid_q, pf_sid_q;
  logic [lobm_pkg::PRICE_W-1:0] pf_px_q;
  logic [lobm_pkg::QTY_W-1:0] pf_qty_q;
  lobm_pkg::status_e          st_q;
  logic [lobm_pkg::ID_W-1:0]  oid_q;
  logic [CNW-1:0]             sc_cnt_q;
  logic                       sc_pend_q;
  logic [LW-1:0]              sc_t_q;

  logic                       best_bv_q [TICKERS];
  logic [LW-1:0]              best_bl_q [TICKERS];
  logic                       best_sv_q [TICKERS];
  logic [LW-1:0]              best_sl_q [TICKERS];

  logic                       out_valid_q, last_q;
  logic [2:0]                 status_q;
  logic [lobm_pkg::ID_W-1:0]  order_id_q, buy_id_q, sell_id_q;
  logic [lobm_pkg::PRICE_W-1:0] px_q;
  logic [lobm_pkg::QTY_W-1:0] qty_q;

  logic                       s_we, l_we;
  logic [SW-1:0]              s_wa, s_ra;
  logic [LAW-1:0]             l_wa, l_ra;
  slot_rec_t                  s_wd, s_rd, new_rec, rec_w, rs_nxt;
  lvl_rec_t                   l_wd, l_rd;

  logic                       mod_start, mod_done;
  logic [SW-1:0]              mod_rem;

  logic [TW-1:0]              tk;
  logic [BKW-1:0]             cmd_book, bb, sb;
  logic [LW-1:0]              cmd_tick, scan_tick;
  logic [LAW-1:0]             cmd_lv, cur_lv;
  logic                       out_free, crossing, cur_side;
  logic                       side_v;
  logic [LW-1:0]              side_l;
  logic [lobm_pkg::QTY_W-1:0] fq;

  function automatic logic [LAW-1:0] lv_addr(logic [BKW-1:0] book, logic [LW-1:0] tick);
    lv_addr = LAW'(book) * LAW'(PRICE_LEVELS) + LAW'(tick);
  endfunction

  lobm_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_wa),
    .wdata_i (s_wd),
    .raddr_i (s_ra),
    .rdata_o (s_rd)
  );

  lobm_ram #(.WIDTH($bits(lvl_rec_t)), .DEPTH(LEVELS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_wa),
    .wdata_i (l_wd),
    .raddr_i (l_ra),
    .rdata_o (l_rd)
  );

  lobm_mod #(.DIVISOR(ORDER_SLOTS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (q_data_i.id),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign mod_start  = q_pop_o && (q_data_i.kind == lobm_pkg::K_CANCEL);
  assign clearing_o = (state_q == S_CLR);

  assign tk = ((state_q == S_U0) || (state_q == S_U1) || (state_q == S_U2) ||
               (state_q == S_U3) || (state_q == S_RS))
              ? TW'(cur_q.book >> 1) : TW'(cmd_q.ticker);
  assign cmd_book = BKW'({cmd_q.ticker, cmd_q.side});
  assign bb       = BKW'({cmd_q.ticker, 1'b0});
  assign sb       = BKW'({cmd_q.ticker, 1'b1});
  assign cmd_tick = LW'(cmd_q.tick);
  assign cmd_lv   = lv_addr(cmd_book, cmd_tick);
  assign cur_lv   = lv_addr(cur_q.book, cur_q.tick);
  assign cur_side = cur_q.book[0];
  assign side_v   = cur_side ? best_sv_q[tk] : best_bv_q[tk];
  assign side_l   = cur_side ? best_sl_q[tk] : best_bl_q[tk];
  assign scan_tick = cur_side ? LW'(sc_cnt_q) : LW'(PRICE_LEVELS - 1) - LW'(sc_cnt_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign crossing = best_bv_q[tk] && best_sv_q[tk] && (best_bl_q[tk] >= best_sl_q[tk]) &&
                    (cnt_q < cmd_q.lim);
  assign fq       = (rb_q.qty < s_rd.qty) ? rb_q.qty : s_rd.qty;

  always_comb begin
    rs_nxt     = s_rd;
    rs_nxt.qty = s_rd.qty - fq;
  end

  always_comb begin
    new_rec      = '0;
    new_rec.live = 1'b1;
    new_rec.tag  = next_id_q;
    new_rec.qty  = cmd_q.qty;
    new_rec.tick = cmd_tick;
    new_rec.book = cmd_book;
    new_rec.prev = l_rd.active ? link_t'{1'b1, l_rd.tail} : '0;
    new_rec.next = '0;
  end

  always_comb begin
    unique case (ret_q)
      RET_MB:  ret_state = S_M_US;
      RET_MS:  ret_state = S_M_CHK;
      default: ret_state = S_RPT;
    endcase
  end

  always_comb begin
    s_we  = 1'b0;
    s_wa  = next_slot_q;
    s_wd  = '0;
    s_ra  = next_slot_q;
    l_we  = 1'b0;
    l_wa  = cmd_lv;
    l_wd  = '0;
    l_ra  = cmd_lv;
    rec_w = s_rd;
    unique case (state_q)
      S_CLR: begin
        s_we = (32'(clr_q) < ORDER_SLOTS);
        s_wa = SW'(clr_q);
        l_we = (32'(clr_q) < LEVELS);
        l_wa = LAW'(clr_q);
      end
      S_A_CHK: begin
        if (!s_rd.live) begin
          s_we = 1'b1;
          s_wd = new_rec;
          l_we = 1'b1;
          l_wd = l_rd.active ? lvl_rec_t'{1'b1, l_rd.head, next_slot_q}
                             : lvl_rec_t'{1'b1, next_slot_q, next_slot_q};
          s_ra = l_rd.tail;
        end
      end
      S_A_LNK: begin
        rec_w.next = link_t'{1'b1, next_slot_q};
        s_we = 1'b1;
        s_wa = lnk_q;
        s_wd = rec_w;
      end
      S_C_MOD: begin
        s_ra = mod_rem;
      end
      S_U0: begin
        l_ra = cur_lv;
        s_ra = cur_q.prev.idx;
      end
      S_U1: begin
        l_wa = cur_lv;
        if (!cur_q.prev.v && !cur_q.next.v) begin
          l_we = 1'b1;
          l_wd = lvl_rec_t'{1'b0, l_rd.head, l_rd.tail};
        end else if (!cur_q.prev.v) begin
          l_we = 1'b1;
          l_wd = lvl_rec_t'{1'b1, cur_q.next.idx, l_rd.tail};
        end else if (!cur_q.next.v) begin
          l_we = 1'b1;
          l_wd = lvl_rec_t'{1'b1, l_rd.head, cur_q.prev.idx};
        end
        rec_w.next = cur_q.next;
        s_we = cur_q.prev.v;
        s_wa = cur_q.prev.idx;
        s_wd = rec_w;
        s_ra = cur_q.next.idx;
      end
      S_U2: begin
        rec_w.prev = cur_q.prev;
        s_we = cur_q.next.v;
        s_wa = cur_q.next.idx;
        s_wd = rec_w;
      end
      S_U3: begin
        rec_w      = cur_q;
        rec_w.live = 1'b0;
        s_we = 1'b1;
        s_wa = cur_idx_q;
        s_wd = rec_w;
      end
      S_RS: begin
        l_ra = lv_addr(cur_q.book, scan_tick);
      end
      S_M_LVB: begin
        l_ra = lv_addr(bb, bl_q);
      end
      S_M_LVS: begin
        l_ra = lv_addr(sb, sl_q);
      end
      S_M_SB: begin
        s_ra = head_b_q;
      end
      S_M_SS: begin
        s_ra = head_s_q;
      end
      S_M_WB: begin
        s_we = 1'b1;
        s_wa = head_b_q;
        s_wd = rb_q;
      end
      S_M_WS: begin
        s_we = 1'b1;
        s_wa = head_s_q;
        s_wd = rs_q;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= RET_CANCEL;
      cmd_q       <= '0;
      clr_q       <= '0;
      next_id_q   <= '0;
      next_slot_q <= '0;
      cur_q       <= '0;
      rb_q        <= '0;
      rs_q        <= '0;
      cur_idx_q   <= '0;
      lnk_q       <= '0;
      head_b_q    <= '0;
      head_s_q    <= '0;
      emptied_q   <= 1'b0;
      bl_q        <= '0;
      sl_q        <= '0;
      cnt_q       <= '0;
      pf_v_q      <= 1'b0;
      pf_bid_q    <= '0;
      pf_sid_q    <= '0;
      pf_px_q     <= '0;
      pf_qty_q    <= '0;
      st_q        <= lobm_pkg::ST_OK;
      oid_q       <= '0;
      sc_cnt_q    <= '0;
      sc_pend_q   <= 1'b0;
      sc_t_q      <= '0;
      for (int i = 0; i < TICKERS; i++) begin
        best_bv_q[i] <= 1'b0;
        best_bl_q[i] <= '0;
        best_sv_q[i] <= 1'b0;
        best_sl_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      status_q    <= '0;
      order_id_q  <= '0;
      buy_id_q    <= '0;
      sell_id_q   <= '0;
      px_q        <= '0;
      qty_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CLRW'(1);
          if (clr_q == CLRW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q <= q_data_i;
            unique case (q_data_i.kind)
              lobm_pkg::K_ADD:    state_q <= S_A_RD;
              lobm_pkg::K_CANCEL: state_q <= S_C_MOD;
              lobm_pkg::K_MATCH: begin
                cnt_q   <= '0;
                pf_v_q  <= 1'b0;
                state_q <= S_M_CHK;
              end
              default: begin
                st_q    <= q_data_i.status;
                oid_q   <= '0;
                state_q <= S_RPT;
              end
            endcase
          end
        end
        S_RPT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= st_q;
            order_id_q  <= oid_q;
            buy_id_q    <= '0;
            sell_id_q   <= '0;
            px_q        <= '0;
            qty_q       <= '0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_A_RD: begin
          state_q <= S_A_CHK;
        end
        S_A_CHK: begin
          if (s_rd.live) begin
            st_q    <= lobm_pkg::ST_BOOK_FULL;
            oid_q   <= '0;
            state_q <= S_RPT;
          end else if (l_rd.active) begin
            lnk_q   <= l_rd.tail;
            state_q <= S_A_LNK;
          end else begin
            if (cmd_q.side) begin
              if (!best_sv_q[tk] || (cmd_tick < best_sl_q[tk])) begin
                best_sv_q[tk] <= 1'b1;
                best_sl_q[tk] <= cmd_tick;
              end
            end else begin
              if (!best_bv_q[tk] || (cmd_tick > best_bl_q[tk])) begin
                best_bv_q[tk] <= 1'b1;
                best_bl_q[tk] <= cmd_tick;
              end
            end
            state_q <= S_A_DONE;
          end
        end
        S_A_LNK: begin
          state_q <= S_A_DONE;
        end
        S_A_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= lobm_pkg::ST_OK;
            order_id_q  <= next_id_q;
            buy_id_q    <= '0;
            sell_id_q   <= '0;
            px_q        <= '0;
            qty_q       <= '0;
            last_q      <= 1'b1;
            next_id_q   <= next_id_q + lobm_pkg::ID_W'(1);
            if ((next_id_q == '1) || (next_slot_q == SW'(ORDER_SLOTS - 1))) begin
              next_slot_q <= '0;
            end else begin
              next_slot_q <= next_slot_q + SW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_C_MOD: begin
          if (mod_done) begin
            cur_idx_q <= mod_rem;
            state_q   <= S_C_CHK;
          end
        end
        S_C_CHK: begin
          oid_q <= cmd_q.id;
          if (!s_rd.live || (s_rd.tag != cmd_q.id)) begin
            st_q    <= lobm_pkg::ST_BAD_ID;
            state_q <= S_RPT;
          end else begin
            st_q    <= lobm_pkg::ST_OK;
            cur_q   <= s_rd;
            ret_q   <= RET_CANCEL;
            state_q <= S_U0;
          end
        end
        S_U0: begin
          state_q <= S_U1;
        end
        S_U1: begin
          emptied_q <= !cur_q.prev.v && !cur_q.next.v;
          state_q   <= S_U2;
        end
        S_U2: begin
          state_q <= S_U3;
        end
        S_U3: begin
          if (emptied_q && side_v && (side_l == cur_q.tick)) begin
            if (cur_side) begin
              best_sv_q[tk] <= 1'b0;
            end else begin
              best_bv_q[tk] <= 1'b0;
            end
            sc_cnt_q  <= '0;
            sc_pend_q <= 1'b0;
            state_q   <= S_RS;
          end else begin
            state_q <= ret_state;
          end
        end
        S_RS: begin
          if (32'(sc_cnt_q) < PRICE_LEVELS) begin
            sc_pend_q <= 1'b1;
            sc_t_q    <= scan_tick;
            sc_cnt_q  <= sc_cnt_q + CNW'(1);
          end else begin
            sc_pend_q <= 1'b0;
          end
          if (sc_pend_q && l_rd.active) begin
            if (cur_side) begin
              best_sv_q[tk] <= 1'b1;
              best_sl_q[tk] <= sc_t_q;
            end else begin
              best_bv_q[tk] <= 1'b1;
              best_bl_q[tk] <= sc_t_q;
            end
            state_q <= ret_state;
          end else if (!sc_pend_q && (32'(sc_cnt_q) == PRICE_LEVELS)) begin
            state_q <= ret_state;
          end
        end
        S_M_CHK: begin
          if (crossing) begin
            if (!pf_v_q || out_free) begin
              if (pf_v_q) begin
                out_valid_q <= 1'b1;
                status_q    <= lobm_pkg::ST_OK;
                order_id_q  <= '0;
                buy_id_q    <= pf_bid_q;
                sell_id_q   <= pf_sid_q;
                px_q        <= pf_px_q;
                qty_q       <= pf_qty_q;
                last_q      <= 1'b0;
              end
              pf_v_q  <= 1'b0;
              bl_q    <= best_bl_q[tk];
              sl_q    <= best_sl_q[tk];
              state_q <= S_M_LVB;
            end
          end else if (!pf_v_q) begin
            st_q    <= lobm_pkg::ST_NO_MATCH;
            oid_q   <= '0;
            state_q <= S_RPT;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= lobm_pkg::ST_OK;
            order_id_q  <= '0;
            buy_id_q    <= pf_bid_q;
            sell_id_q   <= pf_sid_q;
            px_q        <= pf_px_q;
            qty_q       <= pf_qty_q;
            last_q      <= 1'b1;
            pf_v_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_M_LVB: begin
          state_q <= S_M_LVS;
        end
        S_M_LVS: begin
          head_b_q <= l_rd.head;
          state_q  <= S_M_SB;
        end
        S_M_SB: begin
          head_s_q <= l_rd.head;
          state_q  <= S_M_SS;
        end
        S_M_SS: begin
          rb_q    <= s_rd;
          state_q <= S_M_CALC;
        end
        S_M_CALC: begin
          pf_v_q   <= 1'b1;
          pf_bid_q <= rb_q.tag;
          pf_sid_q <= s_rd.tag;
          pf_px_q  <= lobm_pkg::PRICE_W'(sl_q) + lobm_pkg::PRICE_W'(1);
          pf_qty_q <= fq;
          rb_q.qty <= rb_q.qty - fq;
          rs_q     <= rs_nxt;
          cnt_q    <= cnt_q + lobm_pkg::LIMIT_W'(1);
          state_q  <= S_M_WB;
        end
        S_M_WB: begin
          state_q <= S_M_WS;
        end
        S_M_WS: begin
          state_q <= S_M_UB;
        end
        S_M_UB: begin
          if (rb_q.qty == '0) begin
            cur_q     <= rb_q;
            cur_idx_q <= head_b_q;
            ret_q     <= RET_MB;
            state_q   <= S_U0;
          end else begin
            state_q <= S_M_US;
          end
        end
        S_M_US: begin
          if (rs_q.qty == '0) begin
            cur_q     <= rs_q;
            cur_idx_q <= head_s_q;
            ret_q     <= RET_MS;
            state_q   <= S_U0;
          end else begin
            state_q <= S_M_CHK;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign order_id_o         = order_id_q;
  assign buy_id_o           = buy_id_q;
  assign sell_id_o          = sell_id_q;
  assign fill_price_cents_o = px_q;
  assign fill_quantity_o    = qty_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

// File: design/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Per-ticker limit order book with price-time priority: add, cancel, match.
//
//   beat      dir  handshake                 payload
//   input     in   in_valid_i / in_stall_o   opcode, ticker, side, qty, price,
//                                            cancel id, fill limit
//   result    out  out_valid_o / out_stall_i status, ids, fill price / qty, last
//   config    in   cfg_we_i                  cfg_wdata_i (active tickers)
//
// Cancel first maps the id to a slot index, serially when ORDER_SLOTS is not a
// power of two. Match repeats its fill step per fill, up to the fill limit, plus unlinks.
// Emptying the best level rescans that side of the book, one level per cycle, up
// to PRICE_LEVELS levels. After reset a clearing pass over max(ORDER_SLOTS,
// 2*TICKERS*PRICE_LEVELS) memory entries runs with in_stall_o high.
// A two-entry command queue decouples input beats from the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher #(
  parameter int unsigned PRICE_LEVELS = 1024,
  parameter int unsigned ORDER_SLOTS  = 2048,
  parameter int unsigned TICKERS      = 4,
  parameter int unsigned MAX_FILLS    = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lobm_pkg::ACT_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [lobm_pkg::TICKER_W-1:0] ticker_index_i,
  input  wire logic                          side_sell_i,
  input  wire logic [lobm_pkg::QTY_W-1:0]    quantity_i,
  input  wire logic [lobm_pkg::PRICE_W-1:0]  price_cents_i,
  input  wire logic [lobm_pkg::ID_W-1:0]     cancel_id_i,
  input  wire logic [lobm_pkg::LIMIT_W-1:0]  fill_limit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [lobm_pkg::ID_W-1:0]          order_id_o,
  output logic [lobm_pkg::ID_W-1:0]          buy_id_o,
  output logic [lobm_pkg::ID_W-1:0]          sell_id_o,
  output logic [lobm_pkg::PRICE_W-1:0]       fill_price_cents_o,
  output logic [lobm_pkg::QTY_W-1:0]         fill_quantity_o,
  output logic                               last_o
);

  logic           q_valid, q_pop, clearing;
  lobm_pkg::cmd_t q_data;

  lobm_front #(
    .TICKERS      (TICKERS),
    .PRICE_LEVELS (PRICE_LEVELS),
    .MAX_FILLS    (MAX_FILLS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .hold_i         (clearing),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .ticker_index_i (ticker_index_i),
    .side_sell_i    (side_sell_i),
    .quantity_i     (quantity_i),
    .price_cents_i  (price_cents_i),
    .cancel_id_i    (cancel_id_i),
    .fill_limit_i   (fill_limit_i),
    .pop_i          (q_pop),
    .q_valid_o      (q_valid),
    .q_data_o       (q_data)
  );

  lobm_back #(
    .PRICE_LEVELS (PRICE_LEVELS),
    .ORDER_SLOTS  (ORDER_SLOTS),
    .TICKERS      (TICKERS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (q_data),
    .q_pop_o            (q_pop),
    .clearing_o         (clearing),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .order_id_o         (order_id_o),
    .buy_id_o           (buy_id_o),
    .sell_id_o          (sell_id_o),
    .fill_price_cents_o (fill_price_cents_o),
    .fill_quantity_o    (fill_quantity_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
